### design/bia_pkg.sv
// ----------------------------------------------------------------------------
// bia_pkg
// Shared types and constants of the bitmap id allocator.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int MAX_IDS = 64;
  localparam int IDX_W   = $clog2(MAX_IDS);
  localparam int ID_W    = 17;
  localparam int BASE_W  = 16;
  localparam int CNT_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_COUNT = 1'd1;

  localparam logic [BASE_W-1:0] BASE_RESET  = '0;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_CLAIM   = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_BUSY = 2'd2
  } status_t;

  typedef struct packed {
    op_t             operation;
    logic [ID_W-1:0] requested_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    status_t         status;
  } rsp_t;

endpackage

### design/bitmap_id_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_id_allocator_top
// Path: request registered (in_valid, in_req), then result (done, rsp).
// Throughput: one item per cycle; busy stays low, since the lowest free bit
// of the register-held map is found by a combinational lookup.
// Reset: map cleared (every id free), base_id 0, id_count 64.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_top
  import bia_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req,
  output logic                  done,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic              in_valid;
  req_t              in_req;
  logic [BASE_W-1:0] base_id;
  logic [CNT_W-1:0]  id_count;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_id  <= BASE_RESET;
      id_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_ID:  base_id  <= cfg_data[BASE_W-1:0];
        CFG_ID_COUNT: id_count <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_req <= req;
    end
  end

  bia_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_req   (in_req),
    .base_id  (base_id),
    .id_count (id_count),
    .done     (done),
    .rsp      (rsp)
  );

endmodule

### design/bia_lowest_free.sv
// ----------------------------------------------------------------------------
// bia_lowest_free
// Priority encoder: index of the lowest set bit of a free vector.
// ----------------------------------------------------------------------------
module bia_lowest_free
  import bia_pkg::*;
(
  input  logic [MAX_IDS-1:0] free_bits,
  output logic               found,
  output logic [IDX_W-1:0]   index
);

  logic [MAX_IDS-1:0] lowest;

  // isolate the lowest set bit
  assign lowest = free_bits & (~free_bits + 1'b1);
  assign found  = |free_bits;

  always_comb begin
    index = '0;
    for (int b = 0; b < IDX_W; b++) begin
      for (int i = 0; i < MAX_IDS; i++) begin
        if (((i >> b) & 1) == 1) begin
          index[b] = index[b] | lowest[i];
        end
      end
    end
  end

endmodule

### design/bia_core.sv
// ----------------------------------------------------------------------------
// bia_core
// Id map, request decode and result register.
// ----------------------------------------------------------------------------
module bia_core
  import bia_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  req_t              in_req,
  input  logic [BASE_W-1:0] base_id,
  input  logic [CNT_W-1:0]  id_count,
  output logic              done,
  output rsp_t              rsp
);

  logic [MAX_IDS-1:0] id_map;
  logic [MAX_IDS-1:0] id_map_next;
  logic [MAX_IDS-1:0] active_mask;
  logic [MAX_IDS-1:0] free_bits;
  logic               free_found;
  logic [IDX_W-1:0]   free_index;
  logic [ID_W-1:0]    rel;
  logic               in_range;
  logic [IDX_W-1:0]   req_index;
  logic [IDX_W-1:0]   sel_index;
  rsp_t               rsp_next;

  always_comb begin
    for (int i = 0; i < MAX_IDS; i++) begin
      active_mask[i] = ({{(ID_W-CNT_W){1'b0}}, id_count} > ID_W'(i));
    end
  end

  assign free_bits = ~id_map & active_mask;

  bia_lowest_free u_lowest_free (
    .free_bits (free_bits),
    .found     (free_found),
    .index     (free_index)
  );

  assign rel       = in_req.requested_id - {1'b0, base_id};
  assign in_range  = (in_req.requested_id >= {1'b0, base_id})
                  && (rel < {{(ID_W-CNT_W){1'b0}}, id_count})
                  && (rel < ID_W'(MAX_IDS));
  assign req_index = rel[IDX_W-1:0];

  always_comb begin
    id_map_next = id_map;
    rsp_next    = '{granted_id: '0, status: ST_NONE};
    sel_index   = req_index;
    case (in_req.operation)
      OP_ALLOC: begin
        sel_index = free_index;
        if (free_found) begin
          id_map_next[free_index] = 1'b1;
          rsp_next.status = ST_OK;
        end
      end
      OP_CLAIM: begin
        if (in_range) begin
          if (id_map[req_index]) begin
            rsp_next.status = ST_BUSY;
          end else begin
            id_map_next[req_index] = 1'b1;
            rsp_next.status = ST_OK;
          end
        end
      end
      OP_RELEASE: begin
        if (in_range && id_map[req_index]) begin
          id_map_next[req_index] = 1'b0;
          rsp_next.status = ST_OK;
        end
      end
      default: begin
        rsp_next.status = ST_NONE;
      end
    endcase
    // release reports no id
    if (rsp_next.status == ST_OK && in_req.operation != OP_RELEASE) begin
      rsp_next.granted_id = {1'b0, base_id} + ID_W'(sel_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_map <= '0;
      done   <= 1'b0;
    end else begin
      done <= in_valid;
      if (in_valid) begin
        id_map <= id_map_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule
